>>> sv/slif_pkg.sv
`timescale 1ns / 1ps
// slif_pkg: types and constants shared by the selectable low-pass filter
// holds the sequencer states, register indexes, mac operand struct and the fir coefficient rom
// no dependencies
package slif_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WEIGHT_W   = 16;
  localparam int OUT_W      = 18;
  localparam int OP_W       = 18;
  localparam int ROM_DEPTH  = 64;
  localparam int ROM_AW     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd26214;

  localparam int FIR_SHIFT     = 13;
  localparam int IIR_SHIFT     = 16;
  localparam int IIR_PRE_SHIFT = 4;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;

  typedef struct packed {
    logic                   vld;
    logic                   shl;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mac_op_t;

  // symmetric low-pass taps, signed q1.17, unused tail is zero
  localparam logic signed [OP_W-1:0] COEF_ROM [ROM_DEPTH] = '{
    18'sd194,    18'sd165,    18'sd73,     -18'sd92,    -18'sd330,   -18'sd625,
    -18'sd949,   -18'sd1256,  -18'sd1490,  -18'sd1585,  -18'sd1479,  -18'sd1114,
    -18'sd450,   18'sd529,    18'sd1809,   18'sd3348,   18'sd5071,   18'sd6877,
    18'sd8648,   18'sd10261,  18'sd11595,  18'sd12548,  18'sd13044,  18'sd13044,
    18'sd12548,  18'sd11595,  18'sd10261,  18'sd8648,   18'sd6877,   18'sd5071,
    18'sd3348,   18'sd1809,   18'sd529,    -18'sd450,   -18'sd1114,  -18'sd1479,
    -18'sd1585,  -18'sd1490,  -18'sd1256,  -18'sd949,   -18'sd625,   -18'sd330,
    -18'sd92,    18'sd73,     18'sd165,    18'sd194,
    18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0,
    18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
  };

endpackage

>>> sv/slif_mac.sv
`timescale 1ns / 1ps
// slif_mac: shared multiply-accumulate unit of the selectable low-pass filter
// registered 18x18 product followed by a wide accumulator; depends on slif_pkg
module slif_mac #(
  parameter int ACC_W = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  slif_pkg::mac_op_t       op_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] acc_o
);
  import slif_pkg::*;

  logic signed [2*OP_W-1:0] prod_q;
  logic                     p_vld_q;
  logic                     p_shl_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  term;

  assign prod_x = ACC_W'(prod_q);
  assign term   = p_shl_q ? (prod_x <<< IIR_PRE_SHIFT) : prod_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= op_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= op_i.a * op_i.b;
    p_shl_q <= op_i.shl;
    if (clr_i) begin
      acc_q <= '0;
    end else if (p_vld_q) begin
      acc_q <= acc_q + term;
    end
  end

  assign busy_o = p_vld_q;
  assign acc_o  = acc_q;

endmodule

>>> sv/selectable_lowpass_iir_fir_filter.sv
`timescale 1ns / 1ps
// selectable_lowpass_iir_fir_filter: first-order iir or TAPS-tap fir low-pass
// sample history in a circular memory, one shared mac; depends on slif_pkg and slif_mac
//
//   channel  | signals                              | moves
//   ---------+--------------------------------------+----------------------------------
//   in       | in_valid_i, in_ready_o, sample_i     | one sample per transfer
//   out      | out_valid_o, out_ready_i, filtered_o,| one result per transfer
//            | disabled_error_o                     |
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i      | register write, no wait
//
// fir mode runs TAPS taps per sample, iir mode two, disabled mode none; paced by the single mac
// and the registered history memory read, one tap per cycle
// reset is immediate, no clearing pass; a fill count masks history not yet written
// a result waits in the output register; a stalled output holds the sequencer in its
// last state, a new sample is taken as soon as the sequencer is back in idle
module selectable_lowpass_iir_fir_filter #(
  parameter int TAPS        = 46,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [slif_pkg::OUT_W-1:0]   filtered_o,
  output logic                                disabled_error_o,
  input  logic                                cfg_we_i,
  input  logic [slif_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [slif_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import slif_pkg::*;

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = $clog2(TAPS + 1);
  localparam int ACC_W = SAMPLE_BITS + 28;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(TAPS);
  localparam logic [CW-1:0] AGE_FB    = CW'(1);
  localparam logic [CW-1:0] AGE_LAST  = CW'(2);
  localparam logic [CW-1:0] AGE_TOP   = CW'(TAPS - 1);

  localparam logic signed [ACC_W-1:0] HALF_FIR = ACC_W'(1) <<< (FIR_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] HALF_IIR = ACC_W'(1) <<< (IIR_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN);

  state_e state_q, state_d;

  logic                   en_q, sel_q;
  logic [WEIGHT_W-1:0]    w_q;
  logic [CW-1:0]          fill_q, cnt_q;
  logic [AW-1:0]          hd_q, rp_q, hd_nx;
  logic signed [OUT_W-1:0] last_q;
  logic                   err_q;
  logic signed [ACC_W-1:0] rnd_q, rnd_d;

  logic                   out_vld_q;
  logic signed [OUT_W-1:0] out_filt_q;
  logic                   out_err_q;

  logic [SAMPLE_BITS-1:0] mem [TAPS];
  logic [SAMPLE_BITS-1:0] rd_q;

  logic                   s1_vld_q, s1_last_q, s1_live_q, s1_shl_q;
  logic signed [OP_W-1:0] s1_b_q, b_d;

  logic                   accept, issue, round_go, emit_go, last_issue, drain_done;
  logic                   mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic signed [OUT_W-1:0] sat_y;
  mac_op_t                mac_op;

  function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
    return (p == '0) ? LAST_ADDR : p - AW'(1);
  endfunction

  assign hd_nx      = (hd_q == LAST_ADDR) ? '0 : hd_q + AW'(1);
  assign last_issue = sel_q ? (cnt_q == AGE_TOP) : (cnt_q == AGE_LAST);
  assign drain_done = !s1_vld_q && !mac_busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = en_q ? ST_RUN : ST_EMIT;
      ST_RUN:   if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT:  if (emit_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    round_go   = 1'b0;
    emit_go    = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: ;
      ST_ROUND: round_go = 1'b1;
      ST_EMIT:  emit_go = !out_vld_q || out_ready_i;
      default:  ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // mac operand b per tap
  always_comb begin
    if (sel_q) begin
      b_d = COEF_ROM[ROM_AW'(cnt_q)];
    end else if (cnt_q == AGE_FB) begin
      b_d = OP_W'(17'h10000 - {1'b0, w_q});
    end else begin
      b_d = OP_W'(w_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      en_q      <= 1'b0;
      sel_q     <= 1'b0;
      w_q       <= WEIGHT_RESET;
      fill_q    <= '0;
      hd_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      last_q    <= '0;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
      s1_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      if (accept) begin
        err_q <= !en_q;
        if (en_q) begin
          hd_q   <= hd_nx;
          fill_q <= (fill_q == FILL_MAX) ? fill_q : fill_q + CW'(1);
          cnt_q  <= sel_q ? '0 : AGE_FB;
          rp_q   <= sel_q ? hd_nx : dec_ptr(hd_nx);
        end
      end
      if (issue) begin
        cnt_q <= cnt_q + CW'(1);
        rp_q  <= dec_ptr(rp_q);
      end
      if (emit_go) begin
        out_vld_q <= 1'b1;
        if (!err_q) last_q <= sat_y;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENABLE: begin
            en_q <= cfg_data_i[0];
            if (cfg_data_i[0]) begin
              fill_q <= '0;
              last_q <= '0;
            end
          end
          REG_SELECT: sel_q <= cfg_data_i[0];
          REG_WEIGHT: w_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  // history memory, newest sample at the head
  always_ff @(posedge clk_i) begin
    if (accept && en_q) mem[hd_nx] <= sample_i;
    rd_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= !sel_q && (cnt_q == AGE_LAST);
    s1_shl_q  <= !sel_q && (cnt_q == AGE_FB);
    s1_live_q <= cnt_q < fill_q;
    s1_b_q    <= b_d;
    if (round_go) rnd_q <= rnd_d;
    if (emit_go) begin
      out_filt_q <= err_q ? '0 : sat_y;
      out_err_q  <= err_q;
    end
  end

  assign mac_op = '{
    vld: s1_vld_q,
    shl: s1_shl_q,
    a:   s1_last_q ? last_q : (s1_live_q ? OP_W'(rd_q) : '0),
    b:   s1_b_q
  };

  slif_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (accept),
    .op_i   (mac_op),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  assign rnd_d = sel_q ? ((acc + HALF_FIR) >>> FIR_SHIFT) : ((acc + HALF_IIR) >>> IIR_SHIFT);
  assign sat_y = (rnd_q > SAT_HI) ? OUT_W'(OUT_MAX) :
                 (rnd_q < SAT_LO) ? OUT_W'(OUT_MIN) : OUT_W'(rnd_q);

  assign out_valid_o      = out_vld_q;
  assign filtered_o       = out_filt_q;
  assign disabled_error_o = out_err_q;

endmodule
